@@ src/brlm_pkg.sv @@
// Package of the block RMS level meter: field widths, defaults, shared types.
// Used by the channel interfaces and by every module of the block.
package brlm_pkg;

  localparam int SampleW   = 24;
  localparam int RmsW      = 24;
  localparam int CountW    = 17;
  localparam int SumW      = 64;
  localparam int ProdW     = 2 * SampleW;
  localparam int RootW     = SumW / 2;

  localparam int DefMaxFrames = 65536;
  localparam int DefSampleBits = 24;

  // Operation codes of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [SumW-1:0] a;
    logic [SumW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SumW-1:0] res;
    logic            ge;
  } alu_rsp_t;

  // One finished measurement.
  typedef struct packed {
    logic [RmsW-1:0]   rms;
    logic [CountW-1:0] sample_count;
    logic              overflow;
  } result_t;

endpackage

@@ src/brlm_in_if.sv @@
// Input channel of the level meter: one audio sample and a last-of-block flag.
// Depends on brlm_pkg for the sample width.
interface brlm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [brlm_pkg::SampleW-1:0] sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

@@ src/brlm_out_if.sv @@
// Output channel of the level meter: RMS value, sample count and overflow flag.
// Depends on brlm_pkg for the field widths.
interface brlm_out_if;
  logic                          valid;
  logic                          ready;
  logic [brlm_pkg::RmsW-1:0]     rms;
  logic [brlm_pkg::CountW-1:0]   sample_count;
  logic                          overflow;

  modport source (output valid, output rms, output sample_count, output overflow, input ready);
  modport sink (input valid, input rms, input sample_count, input overflow, output ready);
endinterface

@@ src/brlm_addsub.sv @@
// Shared 64-bit add/subtract unit with an unsigned greater-or-equal flag.
// Depends on brlm_pkg for the request and response types.
module brlm_addsub (
  input  brlm_pkg::alu_req_t req_i,
  output brlm_pkg::alu_rsp_t rsp_o
);
  import brlm_pkg::*;

  logic [SumW:0] wide;

  // One carry chain serves accumulation, division and square root steps.
  always_comb begin
    unique case (req_i.op)
      ALU_ADD: wide = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: wide = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: wide = '0;
    endcase
  end

  // For a subtraction, no borrow means a >= b.
  assign rsp_o.res = wide[SumW-1:0];
  assign rsp_o.ge  = ~wide[SumW];

endmodule

@@ src/brlm_ctrl.sv @@
// Sequencer of the level meter: squares and accumulates samples, then divides
// the sum by the count and takes the square root; all but the squaring use brlm_addsub.
module brlm_ctrl #(
  parameter int MAX_FRAMES  = brlm_pkg::DefMaxFrames,
  parameter int SAMPLE_BITS = brlm_pkg::DefSampleBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [brlm_pkg::SampleW-1:0] sample_i,
  input  logic                                last_i,
  output logic                                done_o,
  output brlm_pkg::result_t                   res_o,
  input  logic                                free_i
);
  import brlm_pkg::*;

  localparam int DivSteps  = SumW;
  localparam int SqrtSteps = SumW / 2;
  localparam int StepW     = $clog2(DivSteps);
  localparam logic [SampleW-1:0] KeepMask =
    ~((SampleW'(1) << (SampleW - SAMPLE_BITS)) - SampleW'(1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_ACC,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [SampleW-1:0] mag_q, mag_d;
  logic               last_q, last_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [SumW-1:0]    rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [StepW-1:0]   step_q, step_d;

  logic [SampleW-1:0] masked;
  logic [SampleW-1:0] mag_in;
  logic [SumW-1:0]    div_trial;
  logic [SumW-1:0]    sqrt_rem;
  logic               below_max;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  brlm_addsub u_addsub (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Magnitude of the sample after dropping the unused low bits.
  assign masked = sample_i & KeepMask;
  assign mag_in = masked[SampleW-1] ? SampleW'((SampleW+1)'(1) << SampleW) -
                                      masked : masked;

  assign below_max = cnt_q < CountW'(MAX_FRAMES);
  assign div_trial = {rem_q[SumW-2:0], quo_q[SumW-1]};
  assign sqrt_rem  = {rem_q[SumW-3:0], quo_q[SumW-1:SumW-2]};

  // Operand selection of the shared unit.
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = sum_q;
    alu_req.b  = SumW'(prod_q);
    unique case (state_q)
      S_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = div_trial;
        alu_req.b  = SumW'(cnt_q);
      end
      S_SQRT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = sqrt_rem;
        alu_req.b  = SumW'({root_q, 2'b01});
      end
      default: ;
    endcase
  end

  // Next-state and datapath updates.
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    last_d  = last_q;
    prod_d  = prod_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    root_d  = root_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mag_d   = mag_in;
          last_d  = last_i;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        prod_d  = mag_q * mag_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        // A sample beyond the maximum block length is dropped.
        if (below_max) begin
          sum_d = alu_rsp.res;
          cnt_d = cnt_q + CountW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        quo_d   = below_max ? alu_rsp.res : sum_q;
        rem_d   = '0;
        step_d  = '0;
        state_d = last_q ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d  = alu_rsp.ge ? alu_rsp.res : div_trial;
        quo_d  = {quo_q[SumW-2:0], alu_rsp.ge};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        // Digit-by-digit square root, two radicand bits per cycle.
        rem_d  = alu_rsp.ge ? alu_rsp.res : sqrt_rem;
        root_d = {root_q[RootW-2:0], alu_rsp.ge};
        quo_d  = {quo_q[SumW-3:0], 2'b00};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(SqrtSteps - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (free_i) begin
          sum_d   = '0;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      step_q  <= step_d;
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    last_q <= last_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign done_o             = (state_q == S_DONE);
  assign res_o.rms          = root_q[RmsW-1:0];
  assign res_o.sample_count = cnt_q;
  assign res_o.overflow     = ovf_q;

endmodule

@@ src/block_rms_level_meter_top.sv @@
// Block RMS level meter, top level with the output register.
// Depends on brlm_pkg, brlm_in_if, brlm_out_if, brlm_ctrl and brlm_addsub.
//
// Usage: in_i carries one signed Q1.23 sample per item and a last flag that
// closes a block. For each block one item leaves on out_o: the RMS level as
// floor(sqrt(floor(sum of squares / count))) in unsigned Q1.23, the number
// of samples counted and an overflow flag. Samples beyond MAX_FRAMES are
// ignored and set the flag.
// Flow: an item that is not last passes through accept, square and accumulate;
// ready is low while the item is squared and accumulated.
// A last item also runs a restoring division and a digit-by-digit square
// root on one shared 64-bit add/subtract unit; when its result reaches out_o,
// ready returns in that same cycle.
// The output register holds a result until it is taken, so the next block can
// be accumulated meanwhile; a finished result waits in the sequencer if the
// previous one is still held, and ready stays low until it moves on.
// Reset clears the sum, count, overflow flag and the output valid.
module block_rms_level_meter_top #(
  parameter int MAX_FRAMES  = brlm_pkg::DefMaxFrames,
  parameter int SAMPLE_BITS = brlm_pkg::DefSampleBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brlm_in_if.sink    in_i,
  brlm_out_if.source out_o
);
  import brlm_pkg::*;

  logic    done;
  logic    free;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  brlm_ctrl #(
    .MAX_FRAMES  (MAX_FRAMES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sample_i   (in_i.sample),
    .last_i     (in_i.last),
    .done_o     (done),
    .res_o      (res),
    .free_i     (free)
  );

  // The output register is free when empty or being taken this cycle.
  assign free        = ~out_valid_q | out_o.ready;
  assign out_valid_d = (done & free) | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && free) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rms          = res_q.rms;
  assign out_o.sample_count = res_q.sample_count;
  assign out_o.overflow     = res_q.overflow;

endmodule

@@ src/brlm_chk.sv @@
// Port-level checks of the block RMS level meter, bound to the top level.
// Depends on brlm_pkg for the field widths.
module brlm_chk #(
  parameter int MAX_FRAMES = brlm_pkg::DefMaxFrames
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [brlm_pkg::RmsW-1:0]     rms_i,
  input logic [brlm_pkg::CountW-1:0]   sample_count_i,
  input logic                          overflow_i
);
  import brlm_pkg::*;

  // The sequencer is busy in the cycle after any accepted item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // A result never exceeds full scale.
  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rms_i <= RmsW'(24'h800000))
    else $error("rms above full scale");

  // Overflow is only reported with a saturated count; the count is never zero.
  a_count_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> sample_count_i != '0 &&
                    (!overflow_i || sample_count_i == CountW'(MAX_FRAMES)))
    else $error("inconsistent sample count or overflow");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(rms_i) &&
                                    $stable(sample_count_i) && $stable(overflow_i))
    else $error("stalled result changed");

endmodule

bind block_rms_level_meter_top brlm_chk #(
  .MAX_FRAMES (MAX_FRAMES)
) u_brlm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .rms_i          (out_o.rms),
  .sample_count_i (out_o.sample_count),
  .overflow_i     (out_o.overflow)
);

@@ test/tb.sv @@
// Testbench of the block RMS level meter: drives sample blocks, predicts each
// block's RMS level, count and overflow flag, and checks every result item.
// Depends on brlm_pkg, brlm_in_if, brlm_out_if and block_rms_level_meter_top.
`timescale 1ns / 100ps

module tb;

  import brlm_pkg::*;

  localparam int MaxFrames  = DefMaxFrames;
  localparam int SampleBits = DefSampleBits;
  localparam int ClkHalf    = 4;
  localparam int DrainCycles = 120;
  localparam int RandomItems = 800;
  localparam int FullBlockLen = 64;

  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};

  // Tracks the running block and the queue of levels still to come out.
  class level_scoreboard;
    logic [SumW-1:0]   energy_sum;
    logic [CountW-1:0] frames_seen;
    logic              too_long;
    result_t           level_q[$];
    int unsigned       n_errors;

    function void clear_block();
      energy_sum  = '0;
      frames_seen = '0;
      too_long    = 1'b0;
    endfunction

    // Largest r with r * r <= v, found one bit at a time from the top.
    function logic [RmsW-1:0] floor_root(logic [SumW-1:0] v);
      logic [SumW-1:0] root;
      logic [SumW-1:0] trial;
      root = '0;
      for (int b = RootW - 1; b >= 0; b--) begin
        trial = root | (SumW'(1) << b);
        if (trial * trial <= v) begin
          root = trial;
        end
      end
      return root[RmsW-1:0];
    endfunction

    // Folds one accepted sample into the block; a last sample closes it.
    function void note_sample(logic signed [SampleW-1:0] s, logic last);
      logic [SampleW-1:0] kept;
      logic [SampleW:0]   mag;
      logic [SumW-1:0]    mag_w;
      result_t            lvl;
      kept = s & ~((SampleW'(1) << (SampleW - SampleBits)) - SampleW'(1));
      mag = kept[SampleW-1] ? -{1'b1, kept} : {1'b0, kept};
      mag_w = SumW'(mag);
      if (frames_seen < CountW'(MaxFrames)) begin
        energy_sum  = energy_sum + mag_w * mag_w;
        frames_seen = frames_seen + 1'b1;
      end else begin
        too_long = 1'b1;
      end
      if (last) begin
        lvl.rms          = floor_root(energy_sum / SumW'(frames_seen));
        lvl.sample_count = frames_seen;
        lvl.overflow     = too_long;
        level_q.push_back(lvl);
        clear_block();
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      n_errors++;
    endtask

    // Compares one result item with the oldest predicted level.
    task check_result(result_t got);
      result_t want;
      if (level_q.size() == 0) begin
        report($sformatf("unexpected result rms=%0d count=%0d overflow=%0b",
                         got.rms, got.sample_count, got.overflow));
      end else begin
        want = level_q.pop_front();
        if (got.rms !== want.rms) begin
          report($sformatf("rms %0d, expected %0d", got.rms, want.rms));
        end
        if (got.sample_count !== want.sample_count) begin
          report($sformatf("sample_count %0d, expected %0d",
                           got.sample_count, want.sample_count));
        end
        if (got.overflow !== want.overflow) begin
          report($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  brlm_in_if  in_if();
  brlm_out_if out_if();

  level_scoreboard sb;

  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned items_sent;

  block_rms_level_meter_top #(
    .MAX_FRAMES (MaxFrames),
    .SAMPLE_BITS(SampleBits)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // A bounded run: anything hanging past this point is a failure.
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  // Draws a sample: mostly full range, some near zero, some at the rails.
  function automatic logic signed [SampleW-1:0] draw_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return r[0] ? SampleMin : SampleMax;
      1, 2: return SampleW'($signed({1'b0, r[7:0]}) * (r[31] ? -1 : 1));
      default: return r[SampleW-1:0];
    endcase
  endfunction

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_sample(logic signed [SampleW-1:0] s, logic last);
    int unsigned gap;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.last   <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s, last);
    items_sent++;
  endtask

  // Sends a whole block of len samples, closed by a last item.
  task automatic send_block(int unsigned len, bit full_scale);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(full_scale ? SampleMin : draw_sample(), i == len - 1);
    end
  endtask

  // Result side: random stalls on ready, every accepted item is checked.
  initial begin
    int unsigned gap;
    result_t got;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.rms          = out_if.rms;
      got.sample_count = out_if.sample_count;
      got.overflow     = out_if.overflow;
      sb.check_result(got);
    end
  end

  // Stimulus: directed blocks, a full-scale block, then random blocks.
  initial begin
    int unsigned blocks;
    sb = new;
    sb.clear_block();
    sb.n_errors = 0;
    items_sent  = 0;
    in_gap_max  = 11;
    out_gap_max = 11;
    rst_n        = 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample blocks at zero, the rails and one step off zero.
    send_sample('0, 1'b1);
    send_sample(SampleMin, 1'b1);
    send_sample(SampleMax, 1'b1);
    send_sample(-24'sd1, 1'b1);
    send_sample(24'sd1, 1'b1);
    // Short blocks where the divide or the root truncates.
    send_sample(24'sd3, 1'b0);
    send_sample(24'sd4, 1'b1);
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample(24'sh555555, 1'b0);
    send_sample(-24'sh2AAAAB, 1'b0);
    send_sample('0, 1'b1);
    send_sample(24'sd7, 1'b0);
    send_sample(-24'sd7, 1'b0);
    send_sample(24'sd2, 1'b1);
    // Back-to-back single-sample blocks with no idling anywhere.
    in_gap_max  = 0;
    out_gap_max = 0;
    send_sample(24'sh400000, 1'b1);
    send_sample(-24'sh400000, 1'b1);
    send_sample(24'sh0000FF, 1'b1);

    // Block of rail samples: the level comes out at exactly full scale.
    out_gap_max = 11;
    send_block(FullBlockLen, 1'b1);

    // Random blocks, mostly short, with idling patterns that change.
    blocks = 0;
    while (items_sent < RandomItems) begin
      if (blocks % 8 == 0) begin
        in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 11 : 3);
        out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 11 : 3);
      end
      send_block(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                             : $urandom_range(1, 16), 1'b0);
      blocks++;
    end
    in_if.valid <= 1'b0;

    // Drain what is still in flight, then decide.
    while (sb.level_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.n_errors == 0 && sb.level_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ block_rms_level_meter_top.f @@
src/brlm_pkg.sv
src/brlm_in_if.sv
src/brlm_out_if.sv
src/brlm_addsub.sv
src/brlm_ctrl.sv
src/block_rms_level_meter_top.sv
src/brlm_chk.sv
test/tb.sv
